FILE: design/assert_macros.svh
// Assertion macros shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvt next-cycle check failed");

`endif

FILE: design/mvt_pkg.sv
// Shared types, codes and the step table of the matrix-vector transform block.
package mvt_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_XFORM = 2'd1;
    localparam logic [1:0] OP_TRANS = 2'd2;
    localparam logic [1:0] OP_DET   = 2'd3;

    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam logic KIND_VEC = 1'b0;
    localparam logic KIND_DET = 1'b1;

    localparam logic CFG_IDX_HAND = 1'b0;

    localparam logic [1:0] SRC_VEC = 2'd0;
    localparam logic [1:0] SRC_MAT = 2'd1;
    localparam logic [1:0] SRC_RES = 2'd2;

    localparam int STEP_LAST = 8;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] row;
    } t_cmd;

    typedef struct packed {
        logic [3:0] a_idx;
        logic [1:0] b_src;
        logic [3:0] b_idx;
        logic       first;
        logic       last;
        logic       neg;
    } t_step_ctl;

    function automatic t_step_ctl f_step_ctl(input logic [3:0] step, input logic is_det,
                                             input logic hand);
        t_step_ctl c;
        c = '0;
        if (!is_det) begin
            c.b_src = SRC_VEC;
            case (step)
                4'd0: begin
                    c.a_idx = 4'd0; c.b_idx = 4'd0; c.first = 1'b1;
                end
                4'd1: begin
                    c.a_idx = hand ? 4'd3 : 4'd1; c.b_idx = 4'd1;
                end
                4'd2: begin
                    c.a_idx = hand ? 4'd6 : 4'd2; c.b_idx = 4'd2; c.last = 1'b1;
                end
                4'd3: begin
                    c.a_idx = hand ? 4'd1 : 4'd3; c.b_idx = 4'd0; c.first = 1'b1;
                end
                4'd4: begin
                    c.a_idx = 4'd4; c.b_idx = 4'd1;
                end
                4'd5: begin
                    c.a_idx = hand ? 4'd7 : 4'd5; c.b_idx = 4'd2; c.last = 1'b1;
                end
                4'd6: begin
                    c.a_idx = hand ? 4'd2 : 4'd6; c.b_idx = 4'd0; c.first = 1'b1;
                end
                4'd7: begin
                    c.a_idx = hand ? 4'd5 : 4'd7; c.b_idx = 4'd1;
                end
                4'd8: begin
                    c.a_idx = 4'd8; c.b_idx = 4'd2; c.last = 1'b1;
                end
                default: begin
                    c.a_idx = 4'd0;
                end
            endcase
        end else begin
            case (step)
                4'd0: begin
                    c.a_idx = 4'd4; c.b_src = SRC_MAT; c.b_idx = 4'd8; c.first = 1'b1;
                end
                4'd1: begin
                    c.a_idx = 4'd5; c.b_src = SRC_MAT; c.b_idx = 4'd7;
                    c.neg = 1'b1; c.last = 1'b1;
                end
                4'd2: begin
                    c.a_idx = 4'd3; c.b_src = SRC_MAT; c.b_idx = 4'd8; c.first = 1'b1;
                end
                4'd3: begin
                    c.a_idx = 4'd5; c.b_src = SRC_MAT; c.b_idx = 4'd6;
                    c.neg = 1'b1; c.last = 1'b1;
                end
                4'd4: begin
                    c.a_idx = 4'd3; c.b_src = SRC_MAT; c.b_idx = 4'd7; c.first = 1'b1;
                end
                4'd5: begin
                    c.a_idx = 4'd4; c.b_src = SRC_MAT; c.b_idx = 4'd6;
                    c.neg = 1'b1; c.last = 1'b1;
                end
                4'd6: begin
                    c.a_idx = 4'd0; c.b_src = SRC_RES; c.b_idx = 4'd0; c.first = 1'b1;
                end
                4'd7: begin
                    c.a_idx = 4'd1; c.b_src = SRC_RES; c.b_idx = 4'd1; c.neg = 1'b1;
                end
                4'd8: begin
                    c.a_idx = 4'd2; c.b_src = SRC_RES; c.b_idx = 4'd2; c.last = 1'b1;
                end
                default: begin
                    c.a_idx = 4'd0;
                end
            endcase
        end
        return c;
    endfunction

endpackage

FILE: design/mvt_if.sv
// Request and result channel interfaces of the matrix-vector transform block.
interface mvt_in_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [1:0]                   row_index;
    logic signed [DATA_WIDTH-1:0] in_a;
    logic signed [DATA_WIDTH-1:0] in_b;
    logic signed [DATA_WIDTH-1:0] in_c;

    modport source (output valid, operation, row_index, in_a, in_b, in_c, input ready);
    modport sink (input valid, operation, row_index, in_a, in_b, in_c, output ready);
endinterface

interface mvt_out_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic signed [DATA_WIDTH-1:0] det_value;
    logic                         saturated;

    modport source (output valid, result_kind, out_x, out_y, out_z, det_value, saturated,
                    input ready);
    modport sink (input valid, result_kind, out_x, out_y, out_z, det_value, saturated,
                  output ready);
endinterface

FILE: design/mvt_front.sv
// Front end: takes requests, drops loads of the nonexistent row, and queues the rest.
`include "assert_macros.svh"

module mvt_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mvt_in_if.sink                       i_req,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output mvt_pkg::t_cmd                o_cmd,
    output logic signed [DATA_WIDTH-1:0] o_a,
    output logic signed [DATA_WIDTH-1:0] o_b,
    output logic signed [DATA_WIDTH-1:0] o_c
);
    import mvt_pkg::*;

    logic [1:0]                   r_count;
    logic [1:0]                   n_count;
    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    t_cmd                         r_q_cmd [2];
    logic signed [DATA_WIDTH-1:0] r_q_a [2];
    logic signed [DATA_WIDTH-1:0] r_q_b [2];
    logic signed [DATA_WIDTH-1:0] r_q_c [2];

    logic accept;
    logic drop;
    logic push;
    logic pop;

    assign i_req.ready = (r_count != 2'd2);
    assign accept      = i_req.valid && i_req.ready;
    assign drop        = (i_req.operation == OP_LOAD) && (i_req.row_index == ROW_NONE);
    assign push        = accept && !drop;
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign n_count     = r_count + {1'b0, push} - {1'b0, pop};

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q_cmd[r_rd_ptr];
    assign o_a         = r_q_a[r_rd_ptr];
    assign o_b         = r_q_b[r_rd_ptr];
    assign o_c         = r_q_c[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wr_ptr] <= '{op: i_req.operation, row: i_req.row_index};
            r_q_a[r_wr_ptr]   <= i_req.in_a;
            r_q_b[r_wr_ptr]   <= i_req.in_b;
            r_q_c[r_wr_ptr]   <= i_req.in_c;
        end
    end

    `MVT_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)
    `MVT_ASSERT_NEXT(a_drop_no_entry, i_clk, i_rst_n, accept && drop && !pop,
                     r_count == $past(r_count))

endmodule

FILE: design/mvt_back.sv
// Back end: matrix storage and the shared multiply-accumulate sequencer.
`include "assert_macros.svh"

module mvt_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_hand,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  mvt_pkg::t_cmd                i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    input  logic signed [DATA_WIDTH-1:0] i_c,
    mvt_out_if.source                    o_rsp
);
    import mvt_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = 2 * DATA_WIDTH + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic signed [ACC_W-1:0]      HALF    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [2:0]                   r_state, n_state;
    logic [3:0]                   r_step, n_step;
    logic [1:0]                   r_grp, n_grp;
    logic                         r_is_det, n_is_det;
    logic                         r_sat, n_sat;
    logic                         r_out_valid, n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_mat [9];
    logic signed [DATA_WIDTH-1:0] n_mat [9];

    logic signed [DATA_WIDTH-1:0] r_vec [3];
    logic signed [DATA_WIDTH-1:0] n_vec [3];
    logic signed [DATA_WIDTH-1:0] r_res [3];
    logic signed [DATA_WIDTH-1:0] n_res [3];
    logic signed [DATA_WIDTH-1:0] r_det, n_det;
    logic signed [PROD_W-1:0]     r_prod, n_prod;
    logic signed [ACC_W-1:0]      r_acc, n_acc;
    logic                         r_out_kind, n_out_kind;
    logic signed [DATA_WIDTH-1:0] r_out_x, n_out_x;
    logic signed [DATA_WIDTH-1:0] r_out_y, n_out_y;
    logic signed [DATA_WIDTH-1:0] r_out_z, n_out_z;
    logic signed [DATA_WIDTH-1:0] r_out_det, n_out_det;
    logic                         r_out_sat, n_out_sat;

    t_step_ctl                    ctl;
    logic signed [DATA_WIDTH-1:0] op_a;
    logic signed [DATA_WIDTH-1:0] op_b;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      acc_sum;
    logic signed [ACC_W-1:0]      rnd_sum;
    logic signed [ACC_W-1:0]      rnd_sh;
    logic                         fits;
    logic signed [DATA_WIDTH-1:0] rnd_val;
    logic                         last_grp;

    assign o_cmd_ready = (r_state == ST_IDLE);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.out_x       = r_out_x;
    assign o_rsp.out_y       = r_out_y;
    assign o_rsp.out_z       = r_out_z;
    assign o_rsp.det_value   = r_out_det;
    assign o_rsp.saturated   = r_out_sat;

    always_comb begin
        ctl  = f_step_ctl(r_step, r_is_det, i_hand);
        op_a = r_mat[ctl.a_idx];
        case (ctl.b_src)
            SRC_VEC: op_b = r_vec[ctl.b_idx[1:0]];
            SRC_MAT: op_b = r_mat[ctl.b_idx];
            SRC_RES: op_b = r_res[ctl.b_idx[1:0]];
            default: op_b = '0;
        endcase
    end

    assign w_prod   = op_a * op_b;
    assign prod_ext = ACC_W'(r_prod);
    assign acc_sum  = (ctl.first ? '0 : r_acc) + (ctl.neg ? -prod_ext : prod_ext);

    assign rnd_sum  = r_acc + HALF;
    assign rnd_sh   = rnd_sum >>> FRAC_BITS;
    assign fits     = (&rnd_sh[ACC_W-1:DATA_WIDTH-1]) || !(|rnd_sh[ACC_W-1:DATA_WIDTH-1]);
    assign rnd_val  = fits ? rnd_sh[DATA_WIDTH-1:0] : (rnd_sh[ACC_W-1] ? SAT_MIN : SAT_MAX);
    assign last_grp = r_is_det ? (r_grp == 2'd3) : (r_grp == 2'd2);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_grp       = r_grp;
        n_is_det    = r_is_det;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        n_mat       = r_mat;
        n_vec       = r_vec;
        n_res       = r_res;
        n_det       = r_det;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_kind  = r_out_kind;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;
        n_out_det   = r_out_det;
        n_out_sat   = r_out_sat;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_LOAD: begin
                            for (int r = 0; r < 3; r++) begin
                                if (i_cmd.row == 2'(r)) begin
                                    n_mat[3*r]     = i_a;
                                    n_mat[3*r + 1] = i_b;
                                    n_mat[3*r + 2] = i_c;
                                end
                            end
                        end
                        OP_TRANS: begin
                            n_mat[1] = r_mat[3];
                            n_mat[3] = r_mat[1];
                            n_mat[2] = r_mat[6];
                            n_mat[6] = r_mat[2];
                            n_mat[5] = r_mat[7];
                            n_mat[7] = r_mat[5];
                        end
                        OP_XFORM, OP_DET: begin
                            n_vec[0] = i_a;
                            n_vec[1] = i_b;
                            n_vec[2] = i_c;
                            n_is_det = (i_cmd.op == OP_DET);
                            n_step   = 4'd0;
                            n_grp    = 2'd0;
                            n_sat    = 1'b0;
                            n_state  = ST_MUL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_prod  = w_prod;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc = acc_sum;
                if (ctl.last) begin
                    n_state = ST_RND;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = ST_MUL;
                end
            end
            ST_RND: begin
                if (r_grp == 2'd3) begin
                    n_det = rnd_val;
                end else begin
                    n_res[r_grp] = rnd_val;
                end
                n_sat = r_sat || !fits;
                if (last_grp) begin
                    n_state = ST_DONE;
                end else begin
                    n_grp   = r_grp + 2'd1;
                    n_step  = r_step + 4'd1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_is_det ? KIND_DET : KIND_VEC;
                    n_out_x     = r_is_det ? '0 : r_res[0];
                    n_out_y     = r_is_det ? '0 : r_res[1];
                    n_out_z     = r_is_det ? '0 : r_res[2];
                    n_out_det   = r_is_det ? r_det : '0;
                    n_out_sat   = r_sat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 4'd0;
            r_grp       <= 2'd0;
            r_is_det    <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_grp       <= n_grp;
            r_is_det    <= n_is_det;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            r_mat       <= n_mat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec      <= n_vec;
        r_res      <= n_res;
        r_det      <= n_det;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_out_kind <= n_out_kind;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_z    <= n_out_z;
        r_out_det  <= n_out_det;
        r_out_sat  <= n_out_sat;
    end

    `MVT_ASSERT_SAME(a_step_range, i_clk, i_rst_n, r_state != ST_IDLE,
                     r_step <= 4'(STEP_LAST))
    `MVT_ASSERT_NEXT(a_last_group_done, i_clk, i_rst_n, r_state == ST_RND && last_grp,
                     r_state == ST_DONE)
    `MVT_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n,
                     r_state == ST_DONE && r_out_valid && !o_rsp.ready, r_state == ST_DONE)

endmodule

FILE: design/matrix3x3_vector_transform.sv
// Top level of the 3x3 fixed-point matrix-vector transform block.
//
// Requests arrive on i_req (valid/ready): load a matrix row, transform a vector,
// transpose the stored matrix, or compute its determinant. Transform and determinant
// requests each return one result on o_rsp (valid/ready); loads and transposes return
// nothing. The handedness register lives at APB address 0; bit 0 selects column-wise
// transforms. pready is tied high.
// A two-entry queue sits between the request channel and the execution sequencer, so
// up to two requests are taken while the sequencer works or a result waits.
// Loads and transposes retire in the sequencer's idle state, one per cycle while idle.
// Transforms and determinants share a single multiplier: each product passes through a
// multiply state and an accumulate state, and each rounded value through a rounding state.
// A transform (nine products, three roundings) or a determinant (nine products, four
// roundings) holds the sequencer until its result is written to the output register
// that drives o_rsp.valid.
// When the receiver stalls, the finished result waits in the output register and the
// sequencer holds the next one until that register frees up.
// Reset clears the matrix to zero and handedness to row-wise, and empties the queue.
module matrix3x3_vector_transform #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvt_in_if.sink      i_req,
    mvt_out_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mvt_pkg::*;

    logic                         r_hand;
    logic                         cfg_wr;
    logic                         cmd_valid;
    logic                         cmd_ready;
    t_cmd                         cmd;
    logic signed [DATA_WIDTH-1:0] cmd_a;
    logic signed [DATA_WIDTH-1:0] cmd_b;
    logic signed [DATA_WIDTH-1:0] cmd_c;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_IDX_HAND) ? 32'(r_hand) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hand <= 1'b0;
        end else if (cfg_wr && (paddr[2] == CFG_IDX_HAND)) begin
            r_hand <= pwdata[0];
        end
    end

    mvt_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd),
        .o_a         (cmd_a),
        .o_b         (cmd_b),
        .o_c         (cmd_c)
    );

    mvt_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hand      (r_hand),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_a         (cmd_a),
        .i_b         (cmd_b),
        .i_c         (cmd_c),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the 3x3 fixed-point matrix-vector transform block.
`timescale 1ns / 100ps

module tb_top;
    import mvt_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PERCENT = 7;

    localparam logic [2:0] ADDR_HAND = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    localparam logic signed [95:0] WIDE_HALF = 96'sd32768;
    localparam logic signed [95:0] WIDE_MAX = 96'sd2147483647;
    localparam logic signed [95:0] WIDE_MIN = -96'sd2147483648;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         row;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] det;
        logic               sat;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mvt_in_if #(.DATA_WIDTH(32)) req_if ();
    mvt_out_if #(.DATA_WIDTH(32)) rsp_if ();

    matrix3x3_vector_transform #(
        .DATA_WIDTH(32),
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk,
        .i_rst_n,
        .i_req(req_if),
        .o_rsp(rsp_if),
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    t_req               pending_reqs[$];
    t_result            expected_results[$];
    logic signed [31:0] mat_copy[9];
    logic               hand_copy;
    t_req               next_req;
    bit                 calm;
    bit                 req_took;
    bit                 rsp_took;
    int                 stim_count;
    int                 stall_cycles;
    int                 errors;
    int                 n_loads, n_trans, n_xforms, n_dets, n_checked, n_sat, n_hand_writes;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic signed [95:0] wide_mul(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [95:0] ea, eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    function automatic logic signed [31:0] round_clip(input logic signed [95:0] v,
                                                      inout logic sat);
        logic signed [95:0] r;
        r = (v + WIDE_HALF) >>> FRAC_BITS;
        if (r > WIDE_MAX) begin
            sat = 1'b1;
            return MAXV;
        end
        if (r < WIDE_MIN) begin
            sat = 1'b1;
            return MINV;
        end
        return r[31:0];
    endfunction

    task automatic predict_request(input t_req r);
        t_result            res;
        logic               sat;
        logic signed [95:0] acc;
        logic signed [31:0] m0, m1, m2, t;
        logic signed [31:0] vec[3];
        int                 base, idx;
        sat = 1'b0;
        res = '0;
        case (r.op)
            OP_LOAD: begin
                if (r.row != ROW_NONE) begin
                    base = 3 * int'(r.row);
                    mat_copy[base] = r.a;
                    mat_copy[base + 1] = r.b;
                    mat_copy[base + 2] = r.c;
                    n_loads++;
                end
            end
            OP_TRANS: begin
                t = mat_copy[1]; mat_copy[1] = mat_copy[3]; mat_copy[3] = t;
                t = mat_copy[2]; mat_copy[2] = mat_copy[6]; mat_copy[6] = t;
                t = mat_copy[5]; mat_copy[5] = mat_copy[7]; mat_copy[7] = t;
                n_trans++;
            end
            OP_XFORM: begin
                vec[0] = r.a;
                vec[1] = r.b;
                vec[2] = r.c;
                res.kind = KIND_VEC;
                for (int i = 0; i < 3; i++) begin
                    acc = '0;
                    for (int j = 0; j < 3; j++) begin
                        idx = hand_copy ? (j * 3 + i) : (i * 3 + j);
                        acc = acc + wide_mul(mat_copy[idx], vec[j]);
                    end
                    case (i)
                        0: res.x = round_clip(acc, sat);
                        1: res.y = round_clip(acc, sat);
                        default: res.z = round_clip(acc, sat);
                    endcase
                end
                res.sat = sat;
                expected_results.push_back(res);
                n_xforms++;
            end
            default: begin
                m0 = round_clip(wide_mul(mat_copy[4], mat_copy[8])
                                - wide_mul(mat_copy[5], mat_copy[7]), sat);
                m1 = round_clip(wide_mul(mat_copy[3], mat_copy[8])
                                - wide_mul(mat_copy[5], mat_copy[6]), sat);
                m2 = round_clip(wide_mul(mat_copy[3], mat_copy[7])
                                - wide_mul(mat_copy[4], mat_copy[6]), sat);
                acc = wide_mul(mat_copy[0], m0) - wide_mul(mat_copy[1], m1)
                      + wide_mul(mat_copy[2], m2);
                res.kind = KIND_DET;
                res.det = round_clip(acc, sat);
                res.sat = sat;
                expected_results.push_back(res);
                n_dets++;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none got kind %0d x %h y %h z %h det %h",
                     $time, got.kind, got.x, got.y, got.z, got.det);
            errors++;
        end else begin
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(got.kind));
            compare_field("out_x", want.x, got.x);
            compare_field("out_y", want.y, got.y);
            compare_field("out_z", want.z, got.z);
            compare_field("det_value", want.det, got.det);
            compare_field("saturated", 32'(want.sat), 32'(got.sat));
            n_checked++;
            if (want.sat) n_sat++;
        end
    endtask

    always @(posedge i_clk) begin
        req_took = i_rst_n && req_if.valid && req_if.ready;
        rsp_took = i_rst_n && rsp_if.valid && rsp_if.ready;
        if (rsp_took) begin
            check_result({rsp_if.result_kind, rsp_if.out_x, rsp_if.out_y, rsp_if.out_z,
                          rsp_if.det_value, rsp_if.saturated});
        end
        if (req_took) begin
            predict_request({req_if.operation, req_if.row_index, req_if.in_a, req_if.in_b,
                             req_if.in_c});
        end
        if (req_took || rsp_took || psel) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without a handshake",
                     $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_took) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                next_req = pending_reqs.pop_front();
                req_if.operation <= next_req.op;
                req_if.row_index <= next_req.row;
                req_if.in_a <= next_req.a;
                req_if.in_b <= next_req.b;
                req_if.in_c <= next_req.c;
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic push_req(input logic [1:0] op, input logic [1:0] row,
                            input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        pending_reqs.push_back('{op: op, row: row, a: a, b: b, c: c});
        if (!(op == OP_LOAD && row == ROW_NONE)) stim_count++;
    endtask

    function automatic int pick_class();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 0;
        if (r < 60) return 1;
        if (r < 75) return 4;
        if (r < 90) return 2;
        return 3;
    endfunction

    function automatic logic [31:0] gen_value(input int cls);
        case (cls)
            0: return 32'($urandom_range(524287)) - 32'd262144;
            1: return 32'($urandom_range(33554431)) - 32'd16777216;
            2: return $urandom;
            3: begin
                case ($urandom_range(6))
                    0: return MAXV;
                    1: return MINV;
                    2: return 32'd0;
                    3: return ONE;
                    4: return -ONE;
                    5: return 32'd1;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return 32'(int'($urandom_range(16)) - 8) << 16;
        endcase
    endfunction

    task automatic build_random(input int n_items);
        int          target, mcls, vcls;
        int          r;
        logic [1:0]  op;
        target = stim_count + n_items;
        while (stim_count < target) begin
            if ($urandom_range(99) < 15) begin
                push_req(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom, $urandom,
                         $urandom);
            end else begin
                mcls = pick_class();
                for (int row = 0; row < 3; row++) begin
                    if ($urandom_range(9) != 0) begin
                        push_req(OP_LOAD, 2'(row), gen_value(mcls), gen_value(mcls),
                                 gen_value(mcls));
                    end
                end
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(99);
                    if (r < 50) op = OP_XFORM;
                    else if (r < 75) op = OP_DET;
                    else if (r < 90) op = OP_TRANS;
                    else op = OP_LOAD;
                    vcls = ($urandom_range(9) < 7) ? mcls : pick_class();
                    push_req(op, 2'($urandom_range(3)), gen_value(vcls), gen_value(vcls),
                             gen_value(vcls));
                end
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_if.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_HAND) begin
            hand_copy = data[0];
            n_hand_writes++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.operation = OP_LOAD;
        req_if.row_index = '0;
        req_if.in_a = '0;
        req_if.in_b = '0;
        req_if.in_c = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < 9; i++) mat_copy[i] = '0;
        hand_copy = 1'b0;
        calm = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks on the reset state, rounding, transpose and saturation.
        push_req(OP_XFORM, 2'd0, MAXV, MINV, 32'h1234_5678);
        push_req(OP_DET, 2'd0, '0, '0, '0);
        push_req(OP_LOAD, ROW_NONE, MAXV, MAXV, MAXV);
        push_req(OP_XFORM, 2'd1, ONE, ONE, ONE);
        push_req(OP_LOAD, 2'd0, ONE, '0, '0);
        push_req(OP_LOAD, 2'd1, '0, ONE, '0);
        push_req(OP_LOAD, 2'd2, '0, '0, ONE);
        push_req(OP_XFORM, 2'd2, MAXV, MINV, 32'd1);
        push_req(OP_DET, 2'd3, MAXV, MAXV, MAXV);
        push_req(OP_LOAD, 2'd0, 32'd1, 2 * ONE, -ONE);
        push_req(OP_LOAD, 2'd1, 32'h0000_8000, 3 * ONE, MAXV);
        push_req(OP_LOAD, 2'd2, -4 * ONE, ONE / 2, MINV);
        push_req(OP_XFORM, 2'd0, 32'h0000_8000, '0, '0);
        push_req(OP_XFORM, 2'd0, 32'hffff_8000, '0, '0);
        push_req(OP_XFORM, 2'd0, ONE, 2 * ONE, -3 * ONE);
        push_req(OP_TRANS, 2'd0, '0, '0, '0);
        push_req(OP_XFORM, 2'd0, ONE, 2 * ONE, -3 * ONE);
        push_req(OP_DET, 2'd0, '0, '0, '0);
        push_req(OP_TRANS, ROW_NONE, MAXV, MINV, MAXV);
        push_req(OP_LOAD, 2'd0, MAXV, MAXV, MAXV);
        push_req(OP_LOAD, 2'd1, MAXV, MAXV, MAXV);
        push_req(OP_LOAD, 2'd2, MAXV, MAXV, MAXV);
        push_req(OP_XFORM, 2'd0, MAXV, MAXV, MAXV);
        push_req(OP_XFORM, 2'd0, MINV, MINV, MINV);
        push_req(OP_LOAD, 2'd0, MAXV, '0, '0);
        push_req(OP_LOAD, 2'd1, '0, MAXV, '0);
        push_req(OP_LOAD, 2'd2, '0, '0, MINV);
        push_req(OP_DET, 2'd0, '0, '0, '0);
        drain();

        apb_write(ADDR_HAND, {31'($urandom_range(32'h7fff_ffff)), 1'b1});
        @(posedge i_clk);
        build_random(200);
        drain();

        apb_write(ADDR_UNUSED, 32'h0000_0000);
        apb_write(ADDR_HAND, 32'hffff_fffe);
        @(posedge i_clk);
        calm = 1'b1;
        build_random(250);
        drain();

        calm = 1'b0;
        apb_write(ADDR_HAND, 32'hffff_ffff);
        apb_write(ADDR_UNUSED, 32'h0000_0000);
        @(posedge i_clk);
        build_random(200);
        drain();

        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("Run covered %0d row loads, %0d transposes, %0d transforms, %0d determinants.",
                 n_loads, n_trans, n_xforms, n_dets);
        $display("Checked %0d results (%0d saturated) over %0d handedness writes, %0d errors.",
                 n_checked, n_sat, n_hand_writes, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
